// ----- rtl/lshm_pkg.sv -----
`default_nettype none

package lshm_pkg;

    // Default sizes of the table and the stored fields
    localparam int KEY_BITS_DEF   = 16;
    localparam int CODE_BITS_DEF  = 64;
    localparam int COORD_BITS_DEF = 12;

    // Fixed field widths on the ports
    localparam int OP_W       = 2;
    localparam int CODE_W     = 64;
    localparam int COORD_W    = 12;
    localparam int DIST_W     = 7;
    localparam int STATUS_W   = 3;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 32;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 48;
    localparam int HBC_W     = 5;
    localparam int SEL_W     = 6;
    localparam int SEL_COUNT = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_HASH_BIT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_SELECT_LO  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_SELECT_HI  = 2'd2;

    localparam logic [HBC_W-1:0] HBC_RESET = 5'd16;
    localparam logic [HBC_W-1:0] HBC_MAX   = 5'd16;

    // Operations
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;

    // Popcount chunk handled per cycle
    localparam int POP_CHUNK = 8;

    typedef enum logic [STATUS_W-1:0] {
        ST_CLEARED    = 3'd0,
        ST_INSERTED   = 3'd1,
        ST_COLLISION  = 3'd2,
        ST_EMPTY      = 3'd3,
        ST_NEW        = 3'd4,
        ST_BETTER     = 3'd5,
        ST_NOT_BETTER = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_KEY,
        S_CLEAR,
        S_READ,
        S_EVAL,
        S_POP,
        S_OUT
    } t_state;

    typedef struct packed {
        logic take_in;
        logic key_ld;
        logic sweep;
        logic mem_rd;
        logic eval;
        logic pop_step;
        logic out_ld;
    } t_cmd;

    typedef struct packed {
        logic op_clear;
        logic op_insert;
        logic clr_last;
        logic pop_last;
        logic out_free;
    } t_stat;

    function automatic logic [3:0] popcount8(input logic [POP_CHUNK-1:0] v);
        logic [3:0] c;
        c = '0;
        for (int i = 0; i < POP_CHUNK; i++) begin
            c = c + 4'(v[i]);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/lshm_ctrl.sv -----
`default_nettype none

module lshm_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire lshm_pkg::t_stat i_stat,
    output lshm_pkg::t_cmd       o_cmd
);

    lshm_pkg::t_state r_state;
    lshm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lshm_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            lshm_pkg::S_INIT: begin
                // invalidate every bucket after reset
                o_cmd.sweep = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = lshm_pkg::S_IDLE;
                end
            end
            lshm_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.take_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = lshm_pkg::S_KEY;
                end
            end
            lshm_pkg::S_KEY: begin
                if (i_stat.op_clear) begin
                    n_state = lshm_pkg::S_CLEAR;
                end else begin
                    o_cmd.key_ld = 1'b1;
                    n_state      = lshm_pkg::S_READ;
                end
            end
            lshm_pkg::S_CLEAR: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = lshm_pkg::S_OUT;
                end
            end
            lshm_pkg::S_READ: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = lshm_pkg::S_EVAL;
            end
            lshm_pkg::S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_stat.op_insert ? lshm_pkg::S_OUT : lshm_pkg::S_POP;
            end
            lshm_pkg::S_POP: begin
                o_cmd.pop_step = 1'b1;
                if (i_stat.pop_last) begin
                    n_state = lshm_pkg::S_OUT;
                end
            end
            lshm_pkg::S_OUT: begin
                // hold until the output register can take the result
                if (i_stat.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = lshm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lshm_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/lshm_dp.sv -----
`default_nettype none

module lshm_dp #(
    parameter int KEY_BITS   = lshm_pkg::KEY_BITS_DEF,
    parameter int CODE_BITS  = lshm_pkg::CODE_BITS_DEF,
    parameter int COORD_BITS = lshm_pkg::COORD_BITS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire lshm_pkg::t_cmd                  i_cmd,
    output lshm_pkg::t_stat                      o_stat,
    input  wire [lshm_pkg::IN_DATA_W-1:0]        i_in_data,
    input  wire [lshm_pkg::OP_W-1:0]             i_in_op,
    input  wire                                  i_cfg_we,
    input  wire [lshm_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire [lshm_pkg::CFG_W-1:0]            i_cfg_data,
    input  wire                                  i_out_ready,
    output logic                                 o_out_valid,
    output logic [lshm_pkg::STATUS_W-1:0]        o_out_status,
    output logic [lshm_pkg::OUT_DATA_W-1:0]      o_out_data
);

    localparam int DEPTH   = 1 << KEY_BITS;
    localparam int XY_W    = (COORD_BITS < lshm_pkg::COORD_W) ? COORD_BITS : lshm_pkg::COORD_W;
    localparam int MEM_W   = 2 * XY_W + CODE_BITS;
    localparam int KEY_SEL = (KEY_BITS < lshm_pkg::SEL_COUNT) ? KEY_BITS : lshm_pkg::SEL_COUNT;
    localparam int STEPS   = (CODE_BITS + lshm_pkg::POP_CHUNK - 1) / lshm_pkg::POP_CHUNK;
    localparam int DIFF_W  = STEPS * lshm_pkg::POP_CHUNK;
    localparam int POP_W   = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [lshm_pkg::CODE_W-1:0] CODE_MASK =
        {lshm_pkg::CODE_W{1'b1}} >> (lshm_pkg::CODE_W - CODE_BITS);

    // Configuration registers
    logic [lshm_pkg::HBC_W-1:0] r_hbc;
    logic [lshm_pkg::CFG_W-1:0] r_sel_lo;
    logic [lshm_pkg::CFG_W-1:0] r_sel_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hbc    <= lshm_pkg::HBC_RESET;
            r_sel_lo <= '0;
            r_sel_hi <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lshm_pkg::CFG_HASH_BIT_COUNT: r_hbc    <= i_cfg_data[lshm_pkg::HBC_W-1:0];
                lshm_pkg::CFG_BIT_SELECT_LO:  r_sel_lo <= i_cfg_data;
                lshm_pkg::CFG_BIT_SELECT_HI:  r_sel_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input transaction registers
    logic [lshm_pkg::OP_W-1:0]   r_op;
    logic [lshm_pkg::CODE_W-1:0] r_code;
    logic [XY_W-1:0]             r_x;
    logic [XY_W-1:0]             r_y;
    logic                        r_prev_matched;
    logic [lshm_pkg::DIST_W-1:0] r_prev_dist;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_op           <= i_in_op;
            r_code         <= i_in_data[63:0] & CODE_MASK;
            r_x            <= XY_W'(i_in_data[75:64]);
            r_y            <= XY_W'(i_in_data[87:76]);
            r_prev_matched <= i_in_data[88];
            r_prev_dist    <= i_in_data[95:89];
        end
    end

    // Bucket key from the sampled code bits
    logic [2*lshm_pkg::CFG_W-1:0] sel_all;
    logic [lshm_pkg::HBC_W-1:0]   key_len;
    logic [lshm_pkg::SEL_W-1:0]   pos;
    logic [KEY_BITS-1:0]          key;
    logic [KEY_BITS-1:0]          r_key;

    always_comb begin
        sel_all = {r_sel_hi, r_sel_lo};
        key_len = (r_hbc > lshm_pkg::HBC_MAX) ? lshm_pkg::HBC_MAX : r_hbc;
        key     = '0;
        pos     = '0;
        for (int k = 0; k < KEY_SEL; k++) begin
            pos = sel_all[lshm_pkg::SEL_W*k +: lshm_pkg::SEL_W];
            if (lshm_pkg::HBC_W'(k) < key_len) begin
                key[k] = r_code[pos];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_ld) begin
            r_key <= key;
        end
    end

    // Clear sweep counter
    logic [KEY_BITS-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.sweep) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Bucket memories: valid bits and payload
    logic             r_vmem [DEPTH];
    logic [MEM_W-1:0] r_dmem [DEPTH];
    logic             r_rd_valid;
    logic [MEM_W-1:0] r_rd_data;
    logic             commit;
    logic             v_we;
    logic [KEY_BITS-1:0] v_addr;

    assign commit = i_cmd.eval && (r_op == lshm_pkg::OP_INSERT) && !r_rd_valid;
    assign v_we   = i_cmd.sweep || commit;
    assign v_addr = i_cmd.sweep ? r_cnt : r_key;

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            r_vmem[v_addr] <= commit;
        end
        if (i_cmd.mem_rd) begin
            r_rd_valid <= r_vmem[r_key];
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_dmem[r_key] <= {r_y, r_x, r_code[CODE_BITS-1:0]};
        end
        if (i_cmd.mem_rd) begin
            r_rd_data <= r_dmem[r_key];
        end
    end

    // Hamming distance, one chunk per cycle
    logic [DIFF_W-1:0]           r_diff;
    logic [lshm_pkg::DIST_W-1:0] r_dist;
    logic [POP_W-1:0]            r_pop;

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_diff <= DIFF_W'(r_code[CODE_BITS-1:0] ^ r_rd_data[CODE_BITS-1:0]);
            r_dist <= '0;
            r_pop  <= '0;
        end else if (i_cmd.pop_step) begin
            r_diff <= r_diff >> lshm_pkg::POP_CHUNK;
            r_dist <= r_dist + lshm_pkg::DIST_W'(
                          lshm_pkg::popcount8(r_diff[lshm_pkg::POP_CHUNK-1:0]));
            r_pop  <= r_pop + 1'b1;
        end
    end

    // Result classification
    lshm_pkg::t_status           res_status;
    logic                        res_hit;

    always_comb begin
        res_hit = 1'b0;
        if (r_op == lshm_pkg::OP_CLEAR) begin
            res_status = lshm_pkg::ST_CLEARED;
        end else if (r_op == lshm_pkg::OP_INSERT) begin
            res_status = r_rd_valid ? lshm_pkg::ST_COLLISION : lshm_pkg::ST_INSERTED;
        end else if (!r_rd_valid) begin
            res_status = lshm_pkg::ST_EMPTY;
        end else begin
            res_hit = 1'b1;
            if (!r_prev_matched) begin
                res_status = lshm_pkg::ST_NEW;
            end else if (r_dist < r_prev_dist) begin
                res_status = lshm_pkg::ST_BETTER;
            end else begin
                res_status = lshm_pkg::ST_NOT_BETTER;
            end
        end
    end

    // Output register
    logic                         r_ovalid;
    logic [lshm_pkg::STATUS_W-1:0] r_ostatus;
    logic [lshm_pkg::COORD_W-1:0] r_ox;
    logic [lshm_pkg::COORD_W-1:0] r_oy;
    logic [lshm_pkg::DIST_W-1:0]  r_odist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_ostatus <= res_status;
            r_ox      <= res_hit ? lshm_pkg::COORD_W'(r_rd_data[CODE_BITS +: XY_W]) : '0;
            r_oy      <= res_hit ? lshm_pkg::COORD_W'(r_rd_data[CODE_BITS+XY_W +: XY_W]) : '0;
            r_odist   <= res_hit ? r_dist : '0;
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_out_status = r_ostatus;
    assign o_out_data   = {1'b0, r_odist, r_oy, r_ox};

    assign o_stat.op_clear  = (r_op == lshm_pkg::OP_CLEAR);
    assign o_stat.op_insert = (r_op == lshm_pkg::OP_INSERT);
    assign o_stat.clr_last  = &r_cnt;
    assign o_stat.pop_last  = (r_pop == POP_W'(STEPS - 1));
    assign o_stat.out_free  = !r_ovalid || i_out_ready;

endmodule

`default_nettype wire

// ----- rtl/lsh_hamming_match_table_core.sv -----
`default_nettype none

// Bit-sampling hash table matching binary codes under Hamming distance. Each
// transaction is handled alone: a query passes through the key, read, evaluate,
// popcount and output states to the result register, the popcount unit
// counting one byte of the code difference per cycle; an insert skips the popcount.
// The bucket valid bits live in a 2**KEY_BITS deep memory, so a clear sweeps it
// one entry per cycle. The same sweep runs after reset, and no input
// transaction is taken during it; configuration writes are taken throughout.
// A finished result waits in the output register while the next transaction
// is accepted.
module lsh_hamming_match_table_core #(
    parameter int KEY_BITS   = lshm_pkg::KEY_BITS_DEF,
    parameter int CODE_BITS  = lshm_pkg::CODE_BITS_DEF,
    parameter int COORD_BITS = lshm_pkg::COORD_BITS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // code[63:0], pixel_x[75:64], pixel_y[87:76], prev_matched[88], prev_distance[95:89]
    input  wire [lshm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // opcode[1:0]
    input  wire [lshm_pkg::OP_W-1:0]          s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // match_x[11:0], match_y[23:12], distance[30:24], zero[31]
    output logic [lshm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // status[2:0]
    output logic [lshm_pkg::STATUS_W-1:0]     m_axis_tuser,
    input  wire                               i_cfg_we,
    input  wire [lshm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [lshm_pkg::CFG_W-1:0]         i_cfg_data
);

    lshm_pkg::t_cmd  cmd;
    lshm_pkg::t_stat stat;

    lshm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lshm_dp #(
        .KEY_BITS   (KEY_BITS),
        .CODE_BITS  (CODE_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_in_data    (s_axis_tdata),
        .i_in_op      (s_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_status (m_axis_tuser),
        .o_out_data   (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ----- rtl/lshm_checker.sv -----
`default_nettype none

module lshm_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              s_axis_tvalid,
    input wire                              s_axis_tready,
    input wire                              m_axis_tvalid,
    input wire                              m_axis_tready,
    input wire [lshm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input wire [lshm_pkg::STATUS_W-1:0]     m_axis_tuser
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Results without a bucket hit carry zero fields
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == lshm_pkg::ST_CLEARED ||
                          m_axis_tuser == lshm_pkg::ST_INSERTED ||
                          m_axis_tuser == lshm_pkg::ST_COLLISION ||
                          m_axis_tuser == lshm_pkg::ST_EMPTY)
            |-> m_axis_tdata == '0)
        else $error("nonzero fields on a result without a hit");

    // Distance never exceeds 64 (the default code length), bit 31 is zero and the status code is defined
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[30:24] <= 7'd64 && m_axis_tdata[31] == 1'b0 &&
                          m_axis_tuser <= lshm_pkg::ST_NOT_BETTER)
        else $error("distance or status out of range");

    // A result never appears in the cycle right after an acceptance
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
        else $error("result issued too early");

endmodule

bind lsh_hamming_match_table_core lshm_checker u_lshm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
